@@ hdl/gmhgc_pkg.sv @@
// Shared constants, types and helpers for the grid minimum-height ground classifier.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package gmhgc_pkg;

  // Grid and coordinate sizing
  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int COORD_BITS = 20;

  // Fixed field widths
  localparam int CS_W   = 16;
  localparam int CNT_W  = 7;
  localparam int MHD_W  = 16;
  localparam int OPC_W  = 2;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = (COORD_BITS > CS_W) ? COORD_BITS : CS_W;

  // Cell index sizing: quotients stay below the active counts
  localparam int COL_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DIV_BITS = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
  localparam int CELL_AW  = ROW_BITS + COL_BITS;
  localparam int CELLS    = 1 << CELL_AW;

  // Shared subtractor width: covers offsets, grid limits and shifted divisors
  localparam int LIM_W   = CNT_W + CS_W;
  localparam int ALU_W0  = ((COORD_BITS + 2) > (LIM_W + 1)) ? (COORD_BITS + 2) : (LIM_W + 1);
  localparam int ALU_W   = (ALU_W0 > (CS_W + DIV_BITS + 1)) ? ALU_W0 : (CS_W + DIV_BITS + 1);

  // Sequencer step counter
  localparam int NBR_N     = 9;
  localparam int DEC_STEPS = 4;
  localparam int SEQ_W     = $clog2(2 * DIV_BITS + NBR_N + DEC_STEPS + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [CS_W-1:0]       csize_t;
  typedef logic        [CNT_W-1:0]      cnt_t;
  typedef logic        [MHD_W-1:0]      mhd_t;
  typedef logic signed [ALU_W-1:0]      alu_t;

  // Marker of an empty cell: largest positive coordinate
  localparam coord_t EMPTY_MIN = {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD     = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_CLEAR    = 2'd2
  } opcode_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_CELL_SIZE = 3'd2,
    REG_GRID_COLS = 3'd3,
    REG_GRID_ROWS = 3'd4,
    REG_MAX_HDIFF = 3'd5
  } cfg_reg_t;

  // Settings as seen by the datapath, counts already saturated
  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    csize_t cell_size;
    cnt_t   act_cols;
    cnt_t   act_rows;
    mhd_t   max_height_diff;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] waddr;
    coord_t             wdata;
    logic               re;
    logic [CELL_AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    alu_t a;
    alu_t b;
  } alu_req_t;

  typedef struct packed {
    alu_t diff;
    logic neg;
  } alu_rsp_t;

  // Neighbour visiting order: centre first, then the eight around it
  function automatic logic signed [1:0] nbr_dr(input logic [SEQ_W-1:0] k);
    logic signed [1:0] d;
    case (k)
      SEQ_W'(1), SEQ_W'(2), SEQ_W'(3): d = -2'sd1;
      SEQ_W'(6), SEQ_W'(7), SEQ_W'(8): d = 2'sd1;
      default:                         d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nbr_dc(input logic [SEQ_W-1:0] k);
    logic signed [1:0] d;
    case (k)
      SEQ_W'(1), SEQ_W'(4), SEQ_W'(6): d = -2'sd1;
      SEQ_W'(3), SEQ_W'(5), SEQ_W'(8): d = 2'sd1;
      default:                         d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

@@ hdl/gmhgc_if.sv @@
// Channel interfaces of the ground classifier: input requests, results and settings writes.
// Depends on gmhgc_pkg for payload types.
interface gmhgc_in_if;
  import gmhgc_pkg::*;
  logic               valid;
  logic               ready;
  logic [OPC_W-1:0]   opcode;
  coord_t             pos_x;
  coord_t             pos_y;
  coord_t             pos_z;
  modport source (output valid, opcode, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, pos_z, output ready);
endinterface

interface gmhgc_out_if;
  import gmhgc_pkg::*;
  logic valid;
  logic ready;
  logic is_ground;
  logic outside_grid;
  modport source (output valid, is_ground, outside_grid, input ready);
  modport sink   (input valid, is_ground, outside_grid, output ready);
endinterface

interface gmhgc_cfg_if;
  import gmhgc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

@@ hdl/gmhgc_cfg_regs.sv @@
// Settings registers of the ground classifier, written through the settings channel.
// Depends on gmhgc_pkg and gmhgc_cfg_if.
module gmhgc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  gmhgc_cfg_if.sink         cfg_chan,
  output gmhgc_pkg::cfg_t   cfg
);
  import gmhgc_pkg::*;

  coord_t origin_x_r;
  coord_t origin_y_r;
  csize_t cell_size_r;
  cnt_t   grid_cols_r;
  cnt_t   grid_rows_r;
  mhd_t   max_hdiff_r;

  // Always take a write request
  assign cfg_chan.ready = 1'b1;

  // Update the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      cell_size_r <= CS_W'(1000);
      grid_cols_r <= CNT_W'(64);
      grid_rows_r <= CNT_W'(64);
      max_hdiff_r <= MHD_W'(200);
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.addr)
        REG_ORIGIN_X:  origin_x_r  <= cfg_chan.data[COORD_BITS-1:0];
        REG_ORIGIN_Y:  origin_y_r  <= cfg_chan.data[COORD_BITS-1:0];
        REG_CELL_SIZE: cell_size_r <= cfg_chan.data[CS_W-1:0];
        REG_GRID_COLS: grid_cols_r <= cfg_chan.data[CNT_W-1:0];
        REG_GRID_ROWS: grid_rows_r <= cfg_chan.data[CNT_W-1:0];
        REG_MAX_HDIFF: max_hdiff_r <= cfg_chan.data[MHD_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the grid counts to the store size
  always_comb begin
    cfg.origin_x        = origin_x_r;
    cfg.origin_y        = origin_y_r;
    cfg.cell_size       = cell_size_r;
    cfg.max_height_diff = max_hdiff_r;
    cfg.act_cols        = (int'(grid_cols_r) > MAX_COLS) ? CNT_W'(MAX_COLS) : grid_cols_r;
    cfg.act_rows        = (int'(grid_rows_r) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : grid_rows_r;
  end

endmodule

@@ hdl/gmhgc_alu.sv @@
// Shared subtract-and-compare unit of the ground classifier sequencer.
// Depends on gmhgc_pkg for the operand types.
module gmhgc_alu (
  input  gmhgc_pkg::alu_req_t req,
  output gmhgc_pkg::alu_rsp_t rsp
);
  import gmhgc_pkg::*;

  // Difference and its sign serve offsets, range checks, division and minimum search
  always_comb begin
    rsp.diff = req.a - req.b;
    rsp.neg  = rsp.diff[ALU_W-1];
  end

endmodule

@@ hdl/gmhgc_cell_store.sv @@
// Per-cell minimum-height store: one write port and one registered read port.
// Depends on gmhgc_pkg for the request type and sizes.
module gmhgc_cell_store (
  input  logic                clk,
  input  gmhgc_pkg::mem_req_t req,
  output gmhgc_pkg::coord_t   rd_data
);
  import gmhgc_pkg::*;

  coord_t mem [CELLS];
  coord_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/grid_min_height_ground_classifier.sv @@
// Top level of the grid minimum-height ground classifier: sequencer and datapath registers.
// Depends on gmhgc_pkg, gmhgc_if, gmhgc_cfg_regs, gmhgc_alu and gmhgc_cell_store.
//
//   Channel   Direction  Handshake     Payload
//   in_chan   sink       valid/ready   opcode, pos_x, pos_y, pos_z
//   out_chan  source     valid/ready   is_ground, outside_grid
//   cfg_chan  sink       valid/ready   addr (register index), data
//
// One request at a time; the shared subtractor sets the pace, one operation per cycle.
// Load: offsets, range checks, division, store read and write. Classify: offsets, range checks,
// division, neighbour reads, decision, done. Outside the grid a point leaves after the range
// checks (classify via done). Clear sweeps the store; reset does so before any request.
// A finished result waits in the output register; only the next classify result stalls on it.
module grid_min_height_ground_classifier (
  input  logic         clk,
  input  logic         rst_n,
  gmhgc_in_if.sink     in_chan,
  gmhgc_out_if.source  out_chan,
  gmhgc_cfg_if.sink    cfg_chan
);
  import gmhgc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_WIPE  = 10'b00_0000_0010,
    S_OFFS  = 10'b00_0000_0100,
    S_RANGE = 10'b00_0000_1000,
    S_DIV   = 10'b00_0001_0000,
    S_LDRD  = 10'b00_0010_0000,
    S_LDWR  = 10'b00_0100_0000,
    S_NBR   = 10'b00_1000_0000,
    S_DEC   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  mem_req_t mem_req;
  coord_t   rd_data;

  state_t             state_r, state_nxt;
  logic [SEQ_W-1:0]   step_r, step_nxt;
  logic [CELL_AW-1:0] wipe_r, wipe_nxt;
  logic               out_valid_r;

  logic [OPC_W-1:0]   opc_r;
  coord_t             x_r, y_r, z_r;
  logic [LIM_W-1:0]   limx_r, limy_r;
  alu_t               remx_r, remy_r, dv_r, t_r;
  logic [DIV_BITS-1:0] qx_r, qy_r;
  coord_t             cmin_r, nmin_r;
  logic               outside_r, g1_r, rd_ok_r, rd_first_r;
  logic               res_ground_r, res_outside_r;
  logic               out_ground_r, out_outside_r;

  logic                in_fire, out_free, div_on_y, div_last_x, div_last, range_out;
  logic [ROW_BITS-1:0] row_w;
  logic [COL_BITS-1:0] col_w;
  logic signed [1:0]   dr_w, dc_w;
  logic [ROW_BITS+1:0] nr_w;
  logic [COL_BITS+1:0] nc_w;
  logic                nbr_ok;

  gmhgc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  gmhgc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  gmhgc_cell_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Handshakes
  assign in_chan.ready         = (state_r == S_IDLE);
  assign in_fire               = in_chan.valid && in_chan.ready;
  assign out_free              = !out_valid_r || out_chan.ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.is_ground    = out_ground_r;
  assign out_chan.outside_grid = out_outside_r;

  // Division phase and cell position
  assign div_on_y   = (step_r >= SEQ_W'(DIV_BITS));
  assign div_last_x = (step_r == SEQ_W'(DIV_BITS - 1));
  assign div_last   = (step_r == SEQ_W'(2 * DIV_BITS - 1));
  assign row_w      = qy_r[ROW_BITS-1:0];
  assign col_w      = qx_r[COL_BITS-1:0];

  // Row or column outside when the offset is negative or not below the limit
  assign range_out = outside_r || remy_r[ALU_W-1] || !alu_rsp.neg;

  // Neighbour of the current step, limited to the active grid
  always_comb begin
    dr_w   = nbr_dr(step_r);
    dc_w   = nbr_dc(step_r);
    nr_w   = {2'b00, row_w} + {{ROW_BITS{dr_w[1]}}, dr_w};
    nc_w   = {2'b00, col_w} + {{COL_BITS{dc_w[1]}}, dc_w};
    nbr_ok = !nr_w[ROW_BITS+1] && !nc_w[COL_BITS+1] &&
             (32'(nr_w[ROW_BITS:0]) < 32'(cfg.act_rows)) &&
             (32'(nc_w[COL_BITS:0]) < 32'(cfg.act_cols));
  end

  // Operand selection for the shared subtractor
  always_comb begin
    alu_req.a = '0;
    alu_req.b = '0;
    case (state_r)
      S_OFFS: begin
        alu_req.a = (step_r == '0) ? alu_t'(x_r) : alu_t'(y_r);
        alu_req.b = (step_r == '0) ? alu_t'(cfg.origin_x) : alu_t'(cfg.origin_y);
      end
      S_RANGE: begin
        alu_req.a = (step_r == '0) ? remx_r : remy_r;
        alu_req.b = (step_r == '0) ? alu_t'(limx_r) : alu_t'(limy_r);
      end
      S_DIV: begin
        alu_req.a = div_on_y ? remy_r : remx_r;
        alu_req.b = dv_r;
      end
      S_LDWR: begin
        alu_req.a = alu_t'(z_r);
        alu_req.b = alu_t'(rd_data);
      end
      S_NBR: begin
        alu_req.a = alu_t'(rd_data);
        alu_req.b = alu_t'(nmin_r);
      end
      S_DEC: begin
        case (step_r)
          SEQ_W'(0): begin
            alu_req.a = alu_t'(z_r);
            alu_req.b = alu_t'(cmin_r);
          end
          SEQ_W'(1): begin
            alu_req.a = t_r;
            alu_req.b = alu_t'(cfg.max_height_diff);
          end
          SEQ_W'(2): begin
            alu_req.a = alu_t'(cmin_r);
            alu_req.b = alu_t'(nmin_r);
          end
          default: begin
            alu_req.a = t_r;
            alu_req.b = alu_t'({cfg.cell_size, 1'b0});
          end
        endcase
      end
      default: ;
    endcase
  end

  // Store accesses
  always_comb begin
    mem_req = '0;
    case (state_r)
      S_WIPE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wipe_r;
        mem_req.wdata = EMPTY_MIN;
      end
      S_LDRD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = {row_w, col_w};
      end
      S_LDWR: begin
        mem_req.we    = alu_rsp.neg;
        mem_req.waddr = {row_w, col_w};
        mem_req.wdata = z_r;
      end
      S_NBR: begin
        mem_req.re    = (step_r < SEQ_W'(NBR_N)) && nbr_ok;
        mem_req.raddr = {nr_w[ROW_BITS-1:0], nc_w[COL_BITS-1:0]};
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    wipe_nxt  = wipe_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          step_nxt = '0;
          case (in_chan.opcode)
            OP_CLEAR: begin
              state_nxt = S_WIPE;
              wipe_nxt  = '0;
            end
            OP_LOAD, OP_CLASSIFY: state_nxt = S_OFFS;
            default: ;
          endcase
        end
      end
      S_WIPE: begin
        wipe_nxt = wipe_r + 1'b1;
        if (wipe_r == {CELL_AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_OFFS: begin
        step_nxt = step_r + 1'b1;
        if (step_r == SEQ_W'(1)) begin
          state_nxt = S_RANGE;
          step_nxt  = '0;
        end
      end
      S_RANGE: begin
        step_nxt = step_r + 1'b1;
        if (step_r == SEQ_W'(1)) begin
          step_nxt = '0;
          if (range_out) begin
            state_nxt = (opc_r == OP_CLASSIFY) ? S_DONE : S_IDLE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        step_nxt = step_r + 1'b1;
        if (div_last) begin
          step_nxt  = '0;
          state_nxt = (opc_r == OP_LOAD) ? S_LDRD : S_NBR;
        end
      end
      S_LDRD: state_nxt = S_LDWR;
      S_LDWR: state_nxt = S_IDLE;
      S_NBR: begin
        step_nxt = step_r + 1'b1;
        if (step_r == SEQ_W'(NBR_N)) begin
          step_nxt  = '0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        step_nxt = step_r + 1'b1;
        if (step_r == SEQ_W'(DEC_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers; reset starts the store sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WIPE;
      step_r      <= '0;
      wipe_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      wipe_r  <= wipe_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      opc_r  <= in_chan.opcode;
      x_r    <= in_chan.pos_x;
      y_r    <= in_chan.pos_y;
      z_r    <= in_chan.pos_z;
      limx_r <= LIM_W'(cfg.act_cols) * LIM_W'(cfg.cell_size);
      limy_r <= LIM_W'(cfg.act_rows) * LIM_W'(cfg.cell_size);
    end
    if (state_r == S_DONE && out_free) begin
      out_ground_r  <= res_ground_r;
      out_outside_r <= res_outside_r;
    end
    case (state_r)
      S_OFFS: begin
        if (step_r == '0) begin
          remx_r <= alu_rsp.diff;
        end else begin
          remy_r <= alu_rsp.diff;
        end
      end
      S_RANGE: begin
        if (step_r == '0) begin
          outside_r <= remx_r[ALU_W-1] || !alu_rsp.neg;
        end else begin
          res_outside_r <= range_out;
          res_ground_r  <= 1'b0;
          dv_r          <= alu_t'(cfg.cell_size) << (DIV_BITS - 1);
          qx_r          <= '0;
          qy_r          <= '0;
        end
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle, most significant first
        rd_ok_r    <= 1'b0;
        rd_first_r <= 1'b0;
        if (div_on_y) begin
          qy_r <= (qy_r << 1) | DIV_BITS'(!alu_rsp.neg);
          if (!alu_rsp.neg) begin
            remy_r <= alu_rsp.diff;
          end
        end else begin
          qx_r <= (qx_r << 1) | DIV_BITS'(!alu_rsp.neg);
          if (!alu_rsp.neg) begin
            remx_r <= alu_rsp.diff;
          end
        end
        if (div_last_x) begin
          dv_r <= alu_t'(cfg.cell_size) << (DIV_BITS - 1);
        end else begin
          dv_r <= dv_r >>> 1;
        end
      end
      S_NBR: begin
        // Read data of an address arrives in the next cycle
        rd_ok_r    <= mem_req.re;
        rd_first_r <= (step_r == '0);
        if (rd_first_r) begin
          cmin_r <= rd_data;
          nmin_r <= rd_data;
        end else if (rd_ok_r && alu_rsp.neg) begin
          nmin_r <= rd_data;
        end
      end
      S_DEC: begin
        case (step_r)
          SEQ_W'(0): t_r <= alu_rsp.diff;
          SEQ_W'(1): g1_r <= alu_rsp.neg;
          SEQ_W'(2): t_r <= alu_rsp.diff;
          default:   res_ground_r <= g1_r && alu_rsp.neg;
        endcase
      end
      default: ;
    endcase
  end

  // Store is written only by the sweep or by a load update
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_WIPE || state_r == S_LDWR))
    else $error("cell store written outside sweep or load update");

  // Quotients fall inside the active grid once division ends
  a_cell_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_LDRD) || (state_r == S_NBR && step_r == '0)) |->
    ((32'(col_w) < 32'(cfg.act_cols)) && (32'(row_w) < 32'(cfg.act_rows))))
    else $error("binned cell outside active grid");

  // A result appears only from the done state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised without a finished request");

  // A point outside the grid is never ground
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_outside_r) |-> !out_ground_r)
    else $error("outside point flagged as ground");

endmodule
